// File: hw/rtl/miller_rabin_prime_test_64_assert.svh
// Assertion macros for the primality test block.
`ifndef MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MR_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Types and constants shared by the primality test modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mrpt_pkg;
  localparam int WitnessCount = 12;
  localparam int WitnessIdxWidth = 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV_START, ST_DIV_WAIT, ST_DECOMP, ST_POW_BIT,
    ST_POW_MUL_WAIT, ST_POW_SQR_WAIT, ST_EVAL, ST_SQ_WAIT, ST_NEXT, ST_DONE
  } mrpt_state_t;

  function automatic logic [5:0] witness_value(input logic [WitnessIdxWidth-1:0] k);
    logic [5:0] w;
    case (k)
      4'd0: w = 6'd2;
      4'd1: w = 6'd3;
      4'd2: w = 6'd5;
      4'd3: w = 6'd7;
      4'd4: w = 6'd11;
      4'd5: w = 6'd13;
      4'd6: w = 6'd17;
      4'd7: w = 6'd19;
      4'd8: w = 6'd23;
      4'd9: w = 6'd29;
      4'd10: w = 6'd31;
      4'd11: w = 6'd37;
      default: w = 6'd2;
    endcase
    return w;
  endfunction
endpackage

// File: hw/rtl/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: one doubling and one conditional add per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrpt_mulmod import mrpt_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);
  localparam int CW = $clog2(W);
  logic [W-1:0] xr, yr, acc;
  logic [CW-1:0] cnt;
  logic running;

  // Additions use one spare bit so that the compare against m is exact.
  logic [W:0] dbl, dbl_red, add, add_red;
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    add = dbl_red + {1'b0, xr};
    add_red = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= CW'(W - 1);
        acc <= '0;
        xr <= x;
        yr <= y;
      end else if (running) begin
        acc <= yr[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
        yr <= {yr[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign prod = acc;
endmodule

// File: hw/rtl/mrpt_divmod.sv
// ----------------------------------------------------------------------------
// mrpt_divmod
// Remainder unit: n mod a witness, sixteen bits per step by reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrpt_divmod #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] n,
  input  logic [5:0]   dv,
  output logic         done,
  output logic [5:0]   rem
);
  localparam int NW = ((W + 15) / 16) * 16;
  localparam int NC = NW / 16;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;
  localparam int RS = 28;
  logic [NW-1:0] nr;
  logic [5:0] r, dr;
  logic [CW-1:0] cnt;
  logic running, phase;
  logic [27:0] recip;
  logic [21:0] t, q, qw, diff;
  logic [49:0] qp;

  // The partial remainder stays below the divisor, so t stays below 2^22 and
  // (t * recip) >> RS is the exact quotient for every witness divisor up to 37.
  always_comb begin
    case (dr)
      6'd2:    recip = 28'(((64'd1 << RS) + 64'd1) / 64'd2);
      6'd3:    recip = 28'(((64'd1 << RS) + 64'd2) / 64'd3);
      6'd5:    recip = 28'(((64'd1 << RS) + 64'd4) / 64'd5);
      6'd7:    recip = 28'(((64'd1 << RS) + 64'd6) / 64'd7);
      6'd11:   recip = 28'(((64'd1 << RS) + 64'd10) / 64'd11);
      6'd13:   recip = 28'(((64'd1 << RS) + 64'd12) / 64'd13);
      6'd17:   recip = 28'(((64'd1 << RS) + 64'd16) / 64'd17);
      6'd19:   recip = 28'(((64'd1 << RS) + 64'd18) / 64'd19);
      6'd23:   recip = 28'(((64'd1 << RS) + 64'd22) / 64'd23);
      6'd29:   recip = 28'(((64'd1 << RS) + 64'd28) / 64'd29);
      6'd31:   recip = 28'(((64'd1 << RS) + 64'd30) / 64'd31);
      6'd37:   recip = 28'(((64'd1 << RS) + 64'd36) / 64'd37);
      default: recip = '0;
    endcase
    t = {r, nr[NW-1 -: 16]};
    qp = {28'd0, t} * {22'd0, recip};
    qw = q * {16'd0, dr};
    diff = t - qw;
  end

  // Each sixteen-bit chunk is handled as a quotient phase, then a remainder phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        phase <= 1'b0;
        nr <= NW'(n);
        dr <= dv;
        r <= '0;
        cnt <= CW'(NC - 1);
      end else if (running) begin
        phase <= !phase;
        if (!phase) begin
          q <= qp[49:RS];
        end else begin
          r <= diff[5:0];
          nr <= nr << 16;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            running <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
  assign rem = r;
endmodule

// File: hw/rtl/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Deterministic Miller-Rabin primality test with witnesses 2 through 37.
// ----------------------------------------------------------------------------
// Usage: drive candidate and raise start while busy is low; that edge is the
// input transfer. busy then stays high until the result appears. prime_flag
// is valid for exactly one cycle, marked by done, and that cycle is the
// output transfer; the receiver cannot stall, so the result is simply shown
// once. Only the low VALUE_WIDTH bits of candidate are tested.
// Trivial cases (below 2, two, three, even) are decided in the check state.
// Otherwise each witness round costs a short remainder pass plus one
// bit-serial modular product per multiply and square, so a round takes
// up to about 2*VALUE_WIDTH products. Every product goes through the
// single shared bit-serial multiplier.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// busy and done; no item in flight survives it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_64_assert.svh"
module miller_rabin_prime_test_64 import mrpt_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] candidate,
  output logic        busy,
  output logic        done,
  output logic        prime_flag
);
  localparam int W = VALUE_WIDTH;
  localparam int RW = $clog2(W);

  mrpt_state_t state, state_next;
  logic [W-1:0] n, nm1, d, e, base, x;
  logic [RW-1:0] r, i;
  logic [WitnessIdxWidth-1:0] k;
  logic result;

  logic mul_go, mul_done, div_go, div_done;
  logic [W-1:0] mul_x, mul_y, prod;
  logic [5:0] rem, wv;

  assign wv = witness_value(k);

  mrpt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .x(mul_x), .y(mul_y), .m(n),
    .done(mul_done), .prod(prod)
  );
  mrpt_divmod #(.W(W)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .n(n), .dv(wv),
    .done(div_done), .rem(rem)
  );

  // Sequencer transitions and unit start strobes.
  always_comb begin
    state_next = state;
    mul_go = 1'b0;
    div_go = 1'b0;
    mul_x = x;
    mul_y = base;
    case (state)
      ST_IDLE: if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        if (n < W'(2) || n == W'(2) || n == W'(3) || !n[0]) state_next = ST_DONE;
        else state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_go = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_next = ST_DECOMP;
      ST_DECOMP: begin
        if (rem == '0) state_next = ST_DONE;
        else if (!d[0]) state_next = ST_DECOMP;
        else state_next = ST_POW_BIT;
      end
      ST_POW_BIT: begin
        if (e == '0) state_next = ST_EVAL;
        else if (e[0]) begin
          mul_go = 1'b1;
          state_next = ST_POW_MUL_WAIT;
        end else begin
          mul_go = 1'b1;
          mul_x = base;
          state_next = ST_POW_SQR_WAIT;
        end
      end
      ST_POW_MUL_WAIT: begin
        mul_x = base;
        if (mul_done) begin
          mul_go = 1'b1;
          state_next = ST_POW_SQR_WAIT;
        end
      end
      ST_POW_SQR_WAIT: if (mul_done) state_next = ST_POW_BIT;
      ST_EVAL: begin
        if (x == W'(1) || x == nm1) state_next = ST_NEXT;
        else if (i >= r) state_next = ST_DONE;
        else begin
          mul_go = 1'b1;
          mul_y = x;
          state_next = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: if (mul_done) state_next = ST_EVAL;
      ST_NEXT: begin
        if (k == WitnessIdxWidth'(WitnessCount - 1)) state_next = ST_DONE;
        else state_next = ST_DIV_START;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers follow the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) begin
        n <= candidate[W-1:0];
        nm1 <= candidate[W-1:0] - 1'b1;
        k <= '0;
      end
      ST_CHECK: result <= (n == W'(2)) || (n == W'(3));
      ST_DIV_START: begin
        d <= nm1;
        r <= '0;
      end
      ST_DECOMP: begin
        // A divisible candidate is prime only when it is the witness itself.
        if (rem == '0) result <= (n == W'(wv));
        else if (!d[0]) begin
          d <= d >> 1;
          r <= r + 1'b1;
        end else begin
          e <= d;
          x <= W'(1);
          base <= W'(wv);
          i <= RW'(1);
        end
      end
      ST_POW_BIT: if (!e[0]) e <= e >> 1;
      ST_POW_MUL_WAIT: if (mul_done) begin
        x <= prod;
        e <= e >> 1;
      end
      ST_POW_SQR_WAIT: if (mul_done) base <= prod;
      ST_EVAL: if (!(x == W'(1) || x == nm1) && i >= r) result <= 1'b0;
      ST_SQ_WAIT: if (mul_done) begin
        x <= prod;
        i <= i + 1'b1;
        // Only n-1 passes after a squaring; force a pass on 1 not to occur.
        if (prod == W'(1)) x <= W'(0) - 1'b1 == nm1 ? W'(2) : '0;
      end
      ST_NEXT: begin
        k <= k + 1'b1;
        result <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign prime_flag = result;

  `MR_ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  `MR_ASSERT_NEXT(a_done_once, clk, rst, done, !done)
  `MR_ASSERT_IMPL(a_units_excl, clk, rst, mul_go, !div_go)
endmodule
